FILE: src/snoise_pkg.sv
// shared constants, types and functions for the 3d simplex noise pipeline
`timescale 1ns / 1ps
package snoise_pkg;

  localparam logic [31:0] SkewF3    = 32'd1431655764;
  localparam logic [31:0] UnskewG3  = 32'd715827884;
  localparam logic [31:0] Falloff06 = 32'd161061274;
  localparam logic [15:0] OutScale  = 16'd16748;
  localparam logic [31:0] OutOffset = 32'h0000_8000;
  localparam logic [31:0] G3One     = 32'd2730;
  localparam logic [31:0] G3Two     = 32'd5461;
  localparam logic [31:0] G3Three   = 32'd8192;

  // one corner of the simplex: distances dx, dy and dz
  typedef struct packed {
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
  } corner_t;

  function automatic logic [7:0] perm(input logic [7:0] idx);
    logic [7:0] r;
    case (idx)
      8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
      8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
      8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
      8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
      8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
      8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
      8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
      8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
      8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
      8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
      8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
      8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
      8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
      8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
      8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
      8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
      8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
      8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
      8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
      8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
      8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
      8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
      8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
      8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
      8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
      8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
      8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
      8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
      8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
      8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
      8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
      8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
      8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
      8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
      8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
      8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
      8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
      8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
      8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
      8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
      8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
      8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
      8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
      8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
      8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
      8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
      8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
      8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
      8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
      8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
      8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
      8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
      8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
      8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
      8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
      8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
      8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
      8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
      8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
      8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
      8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
      8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
      8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
      8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // gradient dot product along a cube edge direction chosen by the four hash bits
  function automatic logic [31:0] grad(input logic [3:0] h, input corner_t c);
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] su;
    logic [31:0] sv;
    u = (h < 4'd8) ? c.dx : c.dy;
    if (h < 4'd4) v = c.dy;
    else if (h == 4'd12 || h == 4'd14) v = c.dx;
    else v = c.dz;
    su = h[0] ? (32'd0 - u) : u;
    sv = h[1] ? (32'd0 - v) : v;
    return su + sv;
  endfunction

endpackage

FILE: src/simplex_noise_3d.sv
// top level: 3d simplex noise pipeline, one sample per cycle
`timescale 1ns / 1ps
// throughput: one beat per cycle; busy is always low, results never stall
// the front end takes 8 stages (skew mult, cell, unskew mult, hash rom chain),
// the four corner units 5 stages, then sum, scale mult and offset 4 stages
// reset clears only the valid shift line; payload registers are not reset
module simplex_noise_3d (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  output logic        done_o,
  output logic [15:0] noise_value_o
);

  localparam int unsigned Latency = 17;

  snoise_pkg::corner_t c_w [4];
  logic [3:0]  h_w [4];
  logic [31:0] contrib_w [4];

  // free-running pipeline, no stall path
  assign busy = 1'b0;

  snoise_front u_front (
    .clk_i (clk_i),
    .x_i   (coord_x_i),
    .y_i   (coord_y_i),
    .z_i   (coord_z_i),
    .c0_o  (c_w[0]), .c1_o (c_w[1]), .c2_o (c_w[2]), .c3_o (c_w[3]),
    .h0_o  (h_w[0]), .h1_o (h_w[1]), .h2_o (h_w[2]), .h3_o (h_w[3])
  );

  for (genvar g = 0; g < 4; g++) begin : g_corner
    snoise_corner u_corner (
      .clk_i     (clk_i),
      .c_i       (c_w[g]),
      .hash_i    (h_w[g]),
      .contrib_o (contrib_w[g])
    );
  end

  // back end: pair sums, total, scale, offset
  logic [31:0] pa_q, pb_q, n_q, sc_q;
  logic [15:0] out_q;
  logic [31:0] nsh_d;

  assign nsh_d = 32'($signed(n_q) >>> 8);

  always_ff @(posedge clk_i) begin
    pa_q  <= contrib_w[0] + contrib_w[1];
    pb_q  <= contrib_w[2] + contrib_w[3];
    n_q   <= pa_q + pb_q;
    sc_q  <= 32'(nsh_d * {16'd0, snoise_pkg::OutScale});
    out_q <= 16'(32'($signed(sc_q) >>> 16) + snoise_pkg::OutOffset);
  end

  // valid bits travel alongside the data
  logic [Latency-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start & ~busy};
    end
  end

  assign done_o        = vld_q[Latency-1];
  assign noise_value_o = out_q;

  // every beat taken yields a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##17 done_o)
    else $error("missing result strobe");

  // no strobe unless its valid bit came down the shift line from the stage before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> vld_q[Latency-1] && $past(vld_q[Latency-2]))
    else $error("result strobe without a beat");

  // pipeline never refuses a beat
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !busy)
    else $error("busy raised");

endmodule

FILE: src/snoise_corner.sv
// falloff and gradient contribution of one simplex corner, registered through stages a to d and an output register
`timescale 1ns / 1ps
module snoise_corner (
  input  logic                   clk_i,
  input  snoise_pkg::corner_t    c_i,
  input  logic [3:0]             hash_i,
  output logic [31:0]            contrib_o
);

  // stage a: squared distances
  snoise_pkg::corner_t c_a_q;
  logic [3:0]  h_a_q;
  logic [31:0] sx_a_q, sy_a_q, sz_a_q;
  // stage b: falloff
  snoise_pkg::corner_t c_b_q;
  logic [3:0]  h_b_q;
  logic [31:0] t_b_q;
  logic        live_b_q;
  // stage c: first square
  logic [31:0] t2_c_q, g_c_q;
  logic        live_c_q;
  // stage d: second square
  logic [31:0] t4_d_q, g_d_q;
  logic        live_d_q;

  logic [31:0] r_d, t_d, sq1_d, sq2_d, prod_d;

  always_comb begin
    r_d   = snoise_pkg::Falloff06 - sx_a_q - sy_a_q - sz_a_q;
    t_d   = 32'($signed(r_d) >>> 12);
    sq1_d = 32'($signed(32'(t_b_q * t_b_q)) >>> 16);
    sq2_d = 32'($signed(32'(t2_c_q * t2_c_q)) >>> 16);
    prod_d = 32'(t4_d_q * g_d_q);
  end

  always_ff @(posedge clk_i) begin
    c_a_q  <= c_i;
    h_a_q  <= hash_i;
    sx_a_q <= 32'(c_i.dx * c_i.dx);
    sy_a_q <= 32'(c_i.dy * c_i.dy);
    sz_a_q <= 32'(c_i.dz * c_i.dz);

    c_b_q    <= c_a_q;
    h_b_q    <= h_a_q;
    t_b_q    <= t_d;
    live_b_q <= (t_d != 32'd0) && !t_d[31];

    t2_c_q   <= sq1_d;
    g_c_q    <= snoise_pkg::grad(h_b_q, c_b_q);
    live_c_q <= live_b_q;

    t4_d_q   <= sq2_d;
    g_d_q    <= g_c_q;
    live_d_q <= live_c_q;

    contrib_o <= live_d_q ? prod_d : 32'd0;
  end

endmodule

FILE: src/snoise_front.sv
// skew, lattice cell, unskewed distances, corner order and lattice hash
`timescale 1ns / 1ps
module snoise_front (
  input  logic                   clk_i,
  input  logic [31:0]            x_i,
  input  logic [31:0]            y_i,
  input  logic [31:0]            z_i,
  output snoise_pkg::corner_t    c0_o,
  output snoise_pkg::corner_t    c1_o,
  output snoise_pkg::corner_t    c2_o,
  output snoise_pkg::corner_t    c3_o,
  output logic [3:0]             h0_o,
  output logic [3:0]             h1_o,
  output logic [3:0]             h2_o,
  output logic [3:0]             h3_o
);

  // f1: coordinate sum
  logic [31:0] x1_q, y1_q, z1_q;
  logic [33:0] sum1_q;
  // f2: skew product
  logic [31:0] x2_q, y2_q, z2_q, s2_q;
  // f3: cell
  logic [31:0] x3_q, y3_q, z3_q, i3_q, j3_q, k3_q;
  // f4: unskew product
  logic [31:0] x4_q, y4_q, z4_q, i4_q, j4_q, k4_q;
  logic [63:0] t4_q;
  // f5: distances, cell indices carried along
  logic [31:0] x0_5_q, y0_5_q, z0_5_q, i5_q, j5_q, k5_q;
  // f6: order, offsets, innermost rom
  snoise_pkg::corner_t c6_q [4];
  logic [7:0] ia6_q [4], ja6_q [4], pk6_q [4];
  // f7: middle rom
  snoise_pkg::corner_t c7_q [4];
  logic [7:0] ia7_q [4], pj7_q [4];

  logic [65:0] sprod_d;
  logic [31:0] s_d;
  logic [33:0] ijk_d;

  function automatic logic [31:0] cell_dist(input logic [31:0] c, input logic [31:0] ci,
                                            input logic [63:0] t);
    logic [63:0] origin;
    logic [63:0] cs;
    origin = {ci, 32'd0} - t;
    cs = {30'd0, c, 2'b00};
    return 32'(cs - (origin >> 18));
  endfunction

  function automatic logic sge(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) >= $signed(b);
  endfunction

  always_comb begin
    sprod_d = 66'(sum1_q * {2'b00, snoise_pkg::SkewF3});
    s_d     = sprod_d[63:32];
    ijk_d   = {2'b00, i3_q} + {2'b00, j3_q} + {2'b00, k3_q};
  end

  logic [2:0] o1_d, o2_d;
  always_comb begin
    if (sge(x0_5_q, y0_5_q)) begin
      if (sge(y0_5_q, z0_5_q)) begin
        o1_d = 3'b100; o2_d = 3'b110;
      end else if (sge(x0_5_q, z0_5_q)) begin
        o1_d = 3'b100; o2_d = 3'b101;
      end else begin
        o1_d = 3'b001; o2_d = 3'b101;
      end
    end else begin
      if (!sge(y0_5_q, z0_5_q)) begin
        o1_d = 3'b001; o2_d = 3'b011;
      end else if (!sge(x0_5_q, z0_5_q)) begin
        o1_d = 3'b010; o2_d = 3'b011;
      end else begin
        o1_d = 3'b010; o2_d = 3'b110;
      end
    end
  end

  logic [2:0]  off_d [4];
  logic [31:0] g_d [4];
  assign off_d[0] = 3'b000;
  assign off_d[1] = o1_d;
  assign off_d[2] = o2_d;
  assign off_d[3] = 3'b111;
  assign g_d[0] = 32'd0;
  assign g_d[1] = snoise_pkg::G3One;
  assign g_d[2] = snoise_pkg::G3Two;
  assign g_d[3] = snoise_pkg::G3Three;

  always_ff @(posedge clk_i) begin
    x1_q <= x_i; y1_q <= y_i; z1_q <= z_i;
    sum1_q <= {2'b00, x_i} + {2'b00, y_i} + {2'b00, z_i};

    x2_q <= x1_q; y2_q <= y1_q; z2_q <= z1_q;
    s2_q <= s_d;

    x3_q <= x2_q; y3_q <= y2_q; z3_q <= z2_q;
    i3_q <= ({1'b0, x2_q[31:1]} + {1'b0, s2_q[31:1]}) >> 11;
    j3_q <= ({1'b0, y2_q[31:1]} + {1'b0, s2_q[31:1]}) >> 11;
    k3_q <= ({1'b0, z2_q[31:1]} + {1'b0, s2_q[31:1]}) >> 11;

    x4_q <= x3_q; y4_q <= y3_q; z4_q <= z3_q;
    i4_q <= i3_q; j4_q <= j3_q; k4_q <= k3_q;
    t4_q <= 64'(ijk_d * {2'b00, snoise_pkg::UnskewG3});

    x0_5_q <= cell_dist(x4_q, i4_q, t4_q);
    y0_5_q <= cell_dist(y4_q, j4_q, t4_q);
    z0_5_q <= cell_dist(z4_q, k4_q, t4_q);
    i5_q <= i4_q; j5_q <= j4_q; k5_q <= k4_q;

    for (int n = 0; n < 4; n++) begin
      c6_q[n].dx <= x0_5_q - {17'd0, off_d[n][2], 14'd0} + g_d[n];
      c6_q[n].dy <= y0_5_q - {17'd0, off_d[n][1], 14'd0} + g_d[n];
      c6_q[n].dz <= z0_5_q - {17'd0, off_d[n][0], 14'd0} + g_d[n];
      ia6_q[n] <= i5_q[7:0] + {7'd0, off_d[n][2]};
      ja6_q[n] <= j5_q[7:0] + {7'd0, off_d[n][1]};
      pk6_q[n] <= snoise_pkg::perm(k5_q[7:0] + {7'd0, off_d[n][0]});

      c7_q[n]  <= c6_q[n];
      ia7_q[n] <= ia6_q[n];
      pj7_q[n] <= snoise_pkg::perm(ja6_q[n] + pk6_q[n]);
    end

    c0_o <= c7_q[0]; c1_o <= c7_q[1]; c2_o <= c7_q[2]; c3_o <= c7_q[3];
    h0_o <= 4'(snoise_pkg::perm(ia7_q[0] + pj7_q[0]));
    h1_o <= 4'(snoise_pkg::perm(ia7_q[1] + pj7_q[1]));
    h2_o <= 4'(snoise_pkg::perm(ia7_q[2] + pj7_q[2]));
    h3_o <= 4'(snoise_pkg::perm(ia7_q[3] + pj7_q[3]));
  end

endmodule
